// ===== rtl/core/fqs_pkg.sv =====
package fqs_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 3;
  localparam int POS_W          = 5;
  localparam int MAX_HITS       = 16;
  localparam int HITS_W         = $clog2(MAX_HITS + 1);

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_EMPTY    = 3'd1,
    STS_FULL     = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_FOUND    = 3'd4
  } status_t;

  // per-cell control: load wins over shift
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== rtl/core/fqs_if.sv =====
interface fqs_in_if;
  import fqs_pkg::*;

  logic                      valid;
  logic                      ready;
  cmd_t                      command;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface fqs_out_if;
  import fqs_pkg::*;

  logic                      valid;
  logic                      ready;
  status_t                   status;
  logic signed [VALUE_W-1:0] data_out;
  logic [POS_W-1:0]          position;
  logic                      last;

  modport source (output valid, output status, output data_out, output position,
                  output last, input ready);
  modport sink   (input valid, input status, input data_out, input position,
                  input last, output ready);
endinterface

// ===== rtl/core/fifo_queue_with_search.sv =====
// Queue held in a row of DEPTH cells; cell 0 is the head except while a search rotates.
// Enqueue, dequeue, peek: ST_EXEC registers the result once the output is free.
// Search: the row rotates one cell per cycle, held while a hit waits on a busy
// output, until all DEPTH cells have been compared in cell 0; ST_FLUSH then sends the last beat.
// One item at a time; the next input beat is taken once the previous one is done.
// rst_n (sync, active low) empties the queue; cell contents are not cleared.
module fifo_queue_with_search #(
  parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  fqs_in_if.sink    in_if,
  fqs_out_if.source out_if
);
  import fqs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  cmd_t                  cmd_r;
  logic [DATA_WIDTH-1:0] key_r;
  logic [AW-1:0]         step_r, step_nxt;
  logic [AW:0]           step_inc;
  logic [HITS_W-1:0]     hits_r, hits_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic [POS_W-1:0]      pend_pos_r, pend_pos_nxt;

  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic signed [VALUE_W-1:0] out_data_r, out_data_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                  in_beat;
  logic                  out_free;
  logic                  full;
  logic                  hit;
  logic                  rot;
  logic                  load_en;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.shift = rot;
    assign ctl.load  = load_en && (cnt_r == CW'(i));

    fqs_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .shift_in  (cell_q[(i + 1) % DEPTH]),
      .load_data (key_r),
      .q         (cell_q[i])
    );
  end

  // ---------------------------------------------------------------- control
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_beat     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign full        = (cnt_r == CW'(DEPTH));
  assign step_inc    = {1'b0, step_r} + 1'b1;

  // only occupied slots count; hits past the cap are ignored
  assign hit = (state_r == ST_SEARCH) && (CW'(step_r) < cnt_r) &&
               (cell_q[0] == key_r) && (hits_r < HITS_W'(MAX_HITS));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    hits_nxt       = hits_r;
    pend_valid_nxt = pend_valid_r;
    pend_pos_nxt   = pend_pos_r;
    rot            = 1'b0;
    load_en        = 1'b0;

    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          step_nxt       = '0;
          hits_nxt       = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = (in_if.command == CMD_SEARCH) ? ST_SEARCH : ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_pos_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
          if (cmd_r == CMD_ENQ) begin
            if (full) begin
              out_status_nxt = STS_FULL;
            end else begin
              out_status_nxt = STS_OK;
              load_en        = 1'b1;
              cnt_nxt        = cnt_r + 1'b1;
            end
          end else if (cnt_r == '0) begin
            out_status_nxt = STS_EMPTY;
          end else begin
            out_status_nxt = STS_OK;
            out_data_nxt   = VALUE_W'(signed'(cell_q[0]));
            if (cmd_r == CMD_DEQ) begin
              // old head rotates to the unused end of the row
              rot     = 1'b1;
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end
      end

      ST_SEARCH: begin
        // a hit pushes out the held one; it waits if the output is busy
        if (hit && pend_valid_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_FOUND;
          out_data_nxt   = '0;
          out_pos_nxt    = pend_pos_r;
          out_last_nxt   = 1'b0;
        end
        if (!(hit && pend_valid_r && !out_free)) begin
          rot      = 1'b1;
          step_nxt = step_inc[AW-1:0];
          if (hit) begin
            pend_valid_nxt = 1'b1;
            pend_pos_nxt   = POS_W'(step_inc);
            hits_nxt       = hits_r + 1'b1;
          end
          if (step_r == AW'(DEPTH - 1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_valid_r ? STS_FOUND : STS_NOTFOUND;
          out_data_nxt   = '0;
          out_pos_nxt    = pend_valid_r ? pend_pos_r : '0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      step_r       <= '0;
      hits_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      step_r       <= step_nxt;
      hits_r       <= hits_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_r <= in_if.command;
      key_r <= DATA_WIDTH'(in_if.value);
    end
    pend_pos_r   <= pend_pos_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.status   = out_status_r;
  assign out_if.data_out = out_data_r;
  assign out_if.position = out_pos_r;
  assign out_if.last     = out_last_r;

`ifndef NO_ASSERTIONS
  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_free && cmd_r == CMD_ENQ && !full)
      |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("enqueue did not grow occupancy");

  a_search_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |=> cnt_r == $past(cnt_r))
    else $error("occupancy changed during search");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (hit && pend_valid_r && !out_free) |=> $stable(step_r) && $stable(pend_pos_r))
    else $error("search advanced while a hit was blocked");

  a_hits_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH && hits_r == HITS_W'(MAX_HITS)) |-> !hit)
    else $error("hit reported beyond the cap");
`endif

endmodule

// ===== rtl/core/fqs_cell.sv =====
module fqs_cell #(
  parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  fqs_pkg::cell_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0] shift_in,
  input  logic [DATA_WIDTH-1:0] load_data,
  output logic [DATA_WIDTH-1:0] q
);
  import fqs_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      data_r <= load_data;
    end else if (ctl.shift) begin
      data_r <= shift_in;
    end else begin
      data_r <= data_r;
    end
  end

  assign q = data_r;

endmodule
